### hw/rtl/tccs_pkg.sv
// Shared types, constants and address helpers for the text console.
`default_nettype none
package tccs_pkg;

  localparam int unsigned NUM_COLS   = 80;
  localparam int unsigned NUM_ROWS   = 25;
  localparam int unsigned CELL_COUNT = NUM_COLS * NUM_ROWS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_FILL,
    BK_READ
  } back_state_e;

  typedef struct packed {
    cmd_e             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic             scroll;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
  } cmd_t;

  // logical row -> memory address, with the ring base of the scrolled screen
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] base,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] phys;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= (ROW_W+1)'(NUM_ROWS)) begin
      sum = sum - (ROW_W+1)'(NUM_ROWS);
    end
    phys = sum[ROW_W-1:0];
    return ADDR_W'(phys) * ADDR_W'(NUM_COLS) + ADDR_W'(col);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tccs_front.sv
// Front end: takes requests, tracks the cursor and emits decoded commands.
`default_nettype none
module tccs_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                operation_i,
  input  wire logic [7:0]                char_code_i,
  input  wire logic [7:0]                attribute_i,
  input  wire logic [tccs_pkg::COL_W-1:0] target_col_i,
  input  wire logic [tccs_pkg::ROW_W-1:0] target_row_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output tccs_pkg::cmd_t                 q_cmd_o
);
  import tccs_pkg::*;

  logic [ROW_W-1:0] cur_row_q, cur_row_d;
  logic [COL_W-1:0] cur_col_q, cur_col_d;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W:0]   row_w;
  logic [COL_W-1:0] clamp_col;
  logic [ROW_W-1:0] clamp_row;
  cmd_t             cmd;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign row_inc    = {1'b0, cur_row_q} + (ROW_W+1)'(1);
  assign clamp_col  = (32'(target_col_i) >= NUM_COLS) ? COL_W'(NUM_COLS - 1) : target_col_i;
  assign clamp_row  = (32'(target_row_i) >= NUM_ROWS) ? ROW_W'(NUM_ROWS - 1) : target_row_i;

  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_MOVE;
    cmd.row    = cur_row_q;
    cmd.col    = cur_col_q;
    cmd.ch     = char_code_i;
    cmd.attr   = attribute_i;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    row_w      = {1'b0, cur_row_q};
    case (op_e'(operation_i))
      OP_PUT: begin
        if (char_code_i == NEWLINE_CODE) begin
          cmd.kind  = CMD_MOVE;
          cur_col_d = '0;
          row_w     = row_inc;
        end else begin
          cmd.kind = CMD_PUT;
          if (cur_col_q == COL_W'(NUM_COLS - 1)) begin
            cur_col_d = '0;
            row_w     = row_inc;
          end else begin
            cur_col_d = cur_col_q + COL_W'(1);
          end
        end
        if (row_w == (ROW_W+1)'(NUM_ROWS)) begin
          cmd.scroll = 1'b1;
          cur_row_d  = ROW_W'(NUM_ROWS - 1);
        end else begin
          cur_row_d  = row_w[ROW_W-1:0];
        end
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      OP_SET: begin
        cmd.kind  = CMD_MOVE;
        cur_col_d = clamp_col;
        cur_row_d = clamp_row;
      end
      OP_READ: begin
        cmd.kind = CMD_READ;
        cmd.row  = clamp_row;
        cmd.col  = clamp_col;
      end
      default: begin
        cmd.kind = CMD_MOVE;
      end
    endcase
    cmd.cur_row = cur_row_d;
    cmd.cur_col = cur_col_d;
  end

  assign q_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
    end else if (q_push_o) begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_row_q) < NUM_ROWS) && (32'(cur_col_q) < NUM_COLS))
    else $error("cursor outside screen");

endmodule
`default_nettype wire

### hw/rtl/tccs_cmd_fifo.sv
// Short command queue between front end and back end.
`default_nettype none
module tccs_cmd_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire tccs_pkg::cmd_t cmd_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output tccs_pkg::cmd_t    cmd_o,
  output logic              empty_o
);
  import tccs_pkg::*;

  localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slot_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == CMDQ_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == CMDQ_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty command queue");

endmodule
`default_nettype wire

### hw/rtl/tccs_back.sv
// Back end: screen memory, write/read/fill sequencer and result register.
`default_nettype none
module tccs_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire tccs_pkg::cmd_t             q_cmd_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [tccs_pkg::CELL_W-1:0]     cell_value_o,
  output logic [tccs_pkg::COL_W-1:0]      cursor_col_out_o,
  output logic [tccs_pkg::ROW_W-1:0]      cursor_row_out_o,
  output logic                            scrolled_o
);
  import tccs_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  cmd_t              cur_cmd;
  logic [ROW_W-1:0]  base_q, base_d;
  logic [ADDR_W-1:0] fill_addr_q, fill_addr_d;
  logic [ADDR_W-1:0] fill_end_q, fill_end_d;
  logic [CELL_W-1:0] fill_data_q, fill_data_d;

  logic [CELL_W-1:0] mem_q [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_scroll_q;
  logic              out_load;
  logic [CELL_W-1:0] out_cell;
  logic              out_scroll;
  logic              out_free;
  logic [ADDR_W-1:0] top_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_cmd  = (state_q == BK_IDLE) ? q_cmd_i : cmd_q;
  assign top_addr = ADDR_W'(base_q) * ADDR_W'(NUM_COLS);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    base_d      = base_q;
    fill_addr_d = fill_addr_q;
    fill_end_d  = fill_end_q;
    fill_data_d = fill_data_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = fill_addr_q;
    mem_wdata   = fill_data_q;
    rd_en       = 1'b0;
    rd_addr     = cell_addr(base_q, q_cmd_i.row, q_cmd_i.col);
    out_load    = 1'b0;
    out_cell    = '0;
    out_scroll  = 1'b0;
    case (state_q)
      BK_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (fill_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = BK_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + ADDR_W'(1);
        end
      end
      BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          case (q_cmd_i.kind)
            CMD_PUT, CMD_MOVE: begin
              if (q_cmd_i.kind == CMD_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(base_q, q_cmd_i.row, q_cmd_i.col);
                mem_wdata = {q_cmd_i.attr, q_cmd_i.ch};
              end
              if (q_cmd_i.scroll) begin
                fill_addr_d = top_addr;
                fill_end_d  = top_addr + ADDR_W'(NUM_COLS - 1);
                fill_data_d = {q_cmd_i.attr, SPACE_CODE};
                state_d     = BK_FILL;
              end else begin
                out_load = 1'b1;
              end
            end
            CMD_CLEAR: begin
              fill_addr_d = '0;
              fill_end_d  = ADDR_W'(CELL_COUNT - 1);
              fill_data_d = {q_cmd_i.attr, SPACE_CODE};
              state_d     = BK_FILL;
            end
            CMD_READ: begin
              rd_en   = 1'b1;
              state_d = BK_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_FILL: begin
        mem_we = 1'b1;
        if (fill_addr_q == fill_end_q) begin
          if (cmd_q.scroll) begin
            base_d = (32'(base_q) == NUM_ROWS - 1) ? '0 : base_q + ROW_W'(1);
          end
          out_load   = 1'b1;
          out_scroll = cmd_q.scroll;
          state_d    = BK_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + ADDR_W'(1);
        end
      end
      BK_READ: begin
        out_load = 1'b1;
        out_cell = rd_data_q;
        state_d  = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    fill_end_q  <= fill_end_d;
    fill_data_q <= fill_data_d;
    if (out_load) begin
      out_cell_q   <= out_cell;
      out_col_q    <= cur_cmd.cur_col;
      out_row_q    <= cur_cmd.cur_row;
      out_scroll_q <= out_scroll;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      base_q      <= '0;
      fill_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      fill_addr_q <= fill_addr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_value_o     = out_cell_q;
  assign cursor_col_out_o = out_col_q;
  assign cursor_row_out_o = out_row_q;
  assign scrolled_o       = out_scroll_q;

  a_base_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) < NUM_ROWS)
    else $error("ring base outside screen");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FILL) |-> (fill_addr_q <= fill_end_q) &&
                             (32'(fill_end_q) < CELL_COUNT))
    else $error("fill sweep out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while held");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ) |=> out_valid_q && (state_q == BK_IDLE))
    else $error("read did not complete");

endmodule
`default_nettype wire

### hw/rtl/text_console_cursor_scroll.sv
// Top level of the text console: front end, command queue and back end.
// Usage:
//   Requests enter on in_valid_i / in_stall_o with operation, character,
//   attribute and target position; each request gives exactly one result on
//   out_valid_o / out_stall_i with the read cell, the cursor and a scroll flag.
//   A request is accepted at a clock edge where valid is high and stall low.
// Results: put, newline and set cursor pass the queue and the result register;
//   a read also passes the registered memory read. A scroll sweeps NUM_COLS
//   cells and a clear CELL_COUNT cells through the single screen memory write port.
// Throughput: one put or set cursor per cycle while results are taken and no
//   scroll or clear runs; a read holds the back end in BK_READ, so the next waits.
// Scrolling rotates a row base over the screen memory, so only the new last
//   line is rewritten.
// Reset: cursor goes to 0,0; the back end then runs a clearing pass over all
//   CELL_COUNT (2000) cells, writing zero to each. Up to two requests
//   queue meanwhile, then in_stall_o rises.
// When the receiver stalls, the result holds and the queue fills; in_stall_o
//   rises once the two-entry queue is full.
`default_nettype none
module text_console_cursor_scroll (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [7:0]                  char_code_i,
  input  wire logic [7:0]                  attribute_i,
  input  wire logic [tccs_pkg::COL_W-1:0]  target_col_i,
  input  wire logic [tccs_pkg::ROW_W-1:0]  target_row_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [tccs_pkg::CELL_W-1:0]      cell_value_o,
  output logic [tccs_pkg::COL_W-1:0]       cursor_col_out_o,
  output logic [tccs_pkg::ROW_W-1:0]       cursor_row_out_o,
  output logic                             scrolled_o
);
  import tccs_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  tccs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .attribute_i  (attribute_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  tccs_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  tccs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_cmd_i          (head_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_value_o     (cell_value_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_row_out_o (cursor_row_out_o),
    .scrolled_o       (scrolled_o)
  );

endmodule
`default_nettype wire
